### rtl/skt_pkg.sv
// Package for the sorted key table lookup block.
// Holds sizes, entry layout, request and status codes and the sequencer states.
// No dependencies.
package skt_pkg;

    // Table geometry
    localparam int MAX_ENTRIES = 4096;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int NUM_WORDS   = 4;
    localparam int WORD_W      = 64;
    localparam int TID_W       = 8;
    localparam int CTR_W       = 32;

    // Configuration port
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 64;
    localparam logic CFG_IDX_MAPPED = 1'b0;

    // Request codes
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    // Status codes
    localparam logic [2:0] ST_HIT  = 3'd0;
    localparam logic [2:0] ST_MISS = 3'd1;
    localparam logic [2:0] ST_ERR  = 3'd2;
    localparam logic [2:0] ST_ACK  = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] key_t;

    typedef struct packed {
        key_t              key;
        logic [TID_W-1:0]  tid;
        word_t             offset;
        word_t             length;
    } entry_t;

    // Result of one key comparison: stored key below or above the search key
    typedef struct packed {
        logic lt;
        logic gt;
    } cmp_res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_PROBE,
        S_CMP,
        S_WL_RD,
        S_WL_CMP,
        S_WR_RD,
        S_WR_CMP,
        S_BOUND,
        S_EMIT
    } skt_state_t;

endpackage

### rtl/skt_if.sv
// Request and response channel interfaces of the sorted key table lookup.
// Depends on skt_pkg.
interface skt_req_if import skt_pkg::*;;
    logic             valid;
    logic             ready;
    logic [1:0]       req_type;
    word_t            key_word0;
    word_t            key_word1;
    word_t            key_word2;
    word_t            key_word3;
    logic [TID_W-1:0] table_tag;
    word_t            blob_offset;
    word_t            blob_length;

    modport source (
        output valid, req_type, key_word0, key_word1, key_word2, key_word3,
               table_tag, blob_offset, blob_length,
        input  ready
    );
    modport sink (
        input  valid, req_type, key_word0, key_word1, key_word2, key_word3,
               table_tag, blob_offset, blob_length,
        output ready
    );
endinterface

interface skt_rsp_if import skt_pkg::*;;
    logic             valid;
    logic             ready;
    logic [2:0]       status;
    word_t            found_offset;
    word_t            found_length;
    logic [CTR_W-1:0] lookup_total;
    logic [CTR_W-1:0] hit_total;
    logic [CTR_W-1:0] miss_total;
    logic [CTR_W-1:0] error_total;

    modport source (
        output valid, status, found_offset, found_length, lookup_total,
               hit_total, miss_total, error_total,
        input  ready
    );
    modport sink (
        input  valid, status, found_offset, found_length, lookup_total,
               hit_total, miss_total, error_total,
        output ready
    );
endinterface

### rtl/sorted_key_table_lookup.sv
// Sorted key table lookup: append, clear and binary-search lookup by 256-bit key.
// Clear, append and reserved requests pass through the execute and emit states.
// A lookup runs binary-search probes (one entry-store read and one key compare each,
// up to ceil(log2(n+1)) probes), then walks any equal-key neighbors, one read and one
// compare each; a found entry gets a bounds check before the response.
// One transaction at a time; the next request is taken once the response is loaded.
// Reset clears counters, entry count and mapped_bytes; the entry store is not cleared.
module sorted_key_table_lookup import skt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    skt_req_if.sink               req,
    skt_rsp_if.source             rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    skt_state_t       state_reg, state_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [CNT_W-1:0] walk_reg, walk_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CTR_W-1:0] lookup_reg, lookup_next;
    logic [CTR_W-1:0] hit_reg, hit_next;
    logic [CTR_W-1:0] miss_reg, miss_next;
    logic [CTR_W-1:0] error_reg, error_next;
    logic [2:0]       res_status_reg, res_status_next;
    logic             out_valid_reg, out_valid_next;
    word_t            mapped_reg;

    // Latched request and found entry payload
    logic [1:0]       req_type_reg;
    key_t             key_reg;
    logic [TID_W-1:0] tid_reg;
    word_t            off_in_reg;
    word_t            len_in_reg;
    word_t            found_off_reg, found_off_next;
    word_t            found_len_reg, found_len_next;

    // Response payload
    logic [2:0]       out_status_reg;
    word_t            out_off_reg;
    word_t            out_len_reg;
    logic [CTR_W-1:0] out_lookup_reg;
    logic [CTR_W-1:0] out_hit_reg;
    logic [CTR_W-1:0] out_miss_reg;
    logic [CTR_W-1:0] out_error_reg;

    logic             req_fire;
    logic             emit_load;
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [CNT_W-1:0] probe_mid;
    entry_t           wr_data;
    entry_t           rd_data;
    cmp_res_t         order;
    logic             key_eq;
    logic             tid_match;
    logic [WORD_W:0]  blob_end;

    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[CFG_ADDR_W-1] == CFG_IDX_MAPPED) ? mapped_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mapped_reg <= '0;
        end
        else if (psel && penable && pwrite && pready
                 && paddr[CFG_ADDR_W-1] == CFG_IDX_MAPPED)
        begin
            mapped_reg <= pwdata;
        end
    end

    // Entry store and shared comparator
    assign wr_data = '{key: key_reg, tid: tid_reg, offset: off_in_reg, length: len_in_reg};

    skt_entry_mem u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    skt_key_cmp u_cmp (
        .stored_key (rd_data.key),
        .search_key (key_reg),
        .order      (order)
    );

    assign key_eq    = !order.lt && !order.gt;
    assign tid_match = (rd_data.tid == tid_reg);
    assign probe_mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign blob_end  = {1'b0, found_off_reg} + {1'b0, found_len_reg};

    // Sequencer: next state, search bounds, counters
    always_comb
    begin
        state_next      = state_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        walk_next       = walk_reg;
        count_next      = count_reg;
        lookup_next     = lookup_reg;
        hit_next        = hit_reg;
        miss_next       = miss_reg;
        error_next      = error_reg;
        res_status_next = res_status_reg;
        found_off_next  = found_off_reg;
        found_len_next  = found_len_reg;
        out_valid_next  = out_valid_reg;
        emit_load       = 1'b0;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = probe_mid[IDX_W-1:0];

        // Drop the response once taken
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_status_next = ST_ACK;
                state_next      = S_EMIT;
                case (req_type_reg)
                    REQ_CLEAR:
                    begin
                        count_next  = '0;
                        lookup_next = '0;
                        hit_next    = '0;
                        miss_next   = '0;
                        error_next  = '0;
                    end
                    REQ_APPEND:
                    begin
                        if (count_reg >= CNT_W'(MAX_ENTRIES))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    REQ_LOOKUP:
                    begin
                        lo_next = '0;
                        hi_next = count_reg;
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_MISS;
                        end
                        else
                        begin
                            state_next = S_PROBE;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_ACK;
                    end
                endcase
            end

            S_PROBE:
            begin
                rd_en      = 1'b1;
                rd_addr    = probe_mid[IDX_W-1:0];
                mid_next   = probe_mid;
                state_next = S_CMP;
            end

            S_CMP:
            begin
                if (order.lt)
                begin
                    lo_next = mid_reg + CNT_W'(1);
                    if (mid_reg + CNT_W'(1) < hi_reg)
                    begin
                        state_next = S_PROBE;
                    end
                    else
                    begin
                        res_status_next = ST_MISS;
                        state_next      = S_EMIT;
                    end
                end
                else if (order.gt)
                begin
                    hi_next = mid_reg;
                    if (lo_reg < mid_reg)
                    begin
                        state_next = S_PROBE;
                    end
                    else
                    begin
                        res_status_next = ST_MISS;
                        state_next      = S_EMIT;
                    end
                end
                else if (tid_match)
                begin
                    found_off_next = rd_data.offset;
                    found_len_next = rd_data.length;
                    state_next     = S_BOUND;
                end
                else if (mid_reg != '0)
                begin
                    walk_next  = mid_reg;
                    state_next = S_WL_RD;
                end
                else if (mid_reg + CNT_W'(1) < count_reg)
                begin
                    walk_next  = mid_reg + CNT_W'(1);
                    state_next = S_WR_RD;
                end
                else
                begin
                    res_status_next = ST_MISS;
                    state_next      = S_EMIT;
                end
            end

            // Walk left across equal keys
            S_WL_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = IDX_W'(walk_reg - CNT_W'(1));
                walk_next  = walk_reg - CNT_W'(1);
                state_next = S_WL_CMP;
            end

            S_WL_CMP:
            begin
                if (key_eq && tid_match)
                begin
                    found_off_next = rd_data.offset;
                    found_len_next = rd_data.length;
                    state_next     = S_BOUND;
                end
                else if (key_eq && walk_reg != '0)
                begin
                    state_next = S_WL_RD;
                end
                else if (mid_reg + CNT_W'(1) < count_reg)
                begin
                    walk_next  = mid_reg + CNT_W'(1);
                    state_next = S_WR_RD;
                end
                else
                begin
                    res_status_next = ST_MISS;
                    state_next      = S_EMIT;
                end
            end

            // Walk right across equal keys
            S_WR_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = walk_reg[IDX_W-1:0];
                state_next = S_WR_CMP;
            end

            S_WR_CMP:
            begin
                if (key_eq && tid_match)
                begin
                    found_off_next = rd_data.offset;
                    found_len_next = rd_data.length;
                    state_next     = S_BOUND;
                end
                else if (key_eq && walk_reg + CNT_W'(1) < count_reg)
                begin
                    walk_next  = walk_reg + CNT_W'(1);
                    state_next = S_WR_RD;
                end
                else
                begin
                    res_status_next = ST_MISS;
                    state_next      = S_EMIT;
                end
            end

            // Check the blob against the mapped region
            S_BOUND:
            begin
                if (blob_end > {1'b0, mapped_reg})
                begin
                    res_status_next = ST_ERR;
                end
                else
                begin
                    res_status_next = ST_HIT;
                end
                state_next = S_EMIT;
            end

            // Load the response once the output register is free
            S_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    emit_load      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    case (res_status_reg)
                        ST_HIT:
                        begin
                            lookup_next = lookup_reg + CTR_W'(1);
                            hit_next    = hit_reg + CTR_W'(1);
                        end
                        ST_MISS:
                        begin
                            lookup_next = lookup_reg + CTR_W'(1);
                            miss_next   = miss_reg + CTR_W'(1);
                        end
                        ST_ERR:
                        begin
                            lookup_next = lookup_reg + CTR_W'(1);
                            error_next  = error_reg + CTR_W'(1);
                        end
                        default:
                        begin
                            lookup_next = lookup_reg;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            lo_reg         <= '0;
            hi_reg         <= '0;
            mid_reg        <= '0;
            walk_reg       <= '0;
            count_reg      <= '0;
            lookup_reg     <= '0;
            hit_reg        <= '0;
            miss_reg       <= '0;
            error_reg      <= '0;
            res_status_reg <= ST_ACK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            mid_reg        <= mid_next;
            walk_reg       <= walk_next;
            count_reg      <= count_next;
            lookup_reg     <= lookup_next;
            hit_reg        <= hit_next;
            miss_reg       <= miss_next;
            error_reg      <= error_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers: request latch, found entry, response
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_type_reg <= req.req_type;
            key_reg      <= {req.key_word0, req.key_word1, req.key_word2, req.key_word3};
            tid_reg      <= req.table_tag;
            off_in_reg   <= req.blob_offset;
            len_in_reg   <= req.blob_length;
        end
        found_off_reg <= found_off_next;
        found_len_reg <= found_len_next;
        if (emit_load)
        begin
            out_status_reg <= res_status_reg;
            out_off_reg    <= (res_status_reg == ST_HIT) ? found_off_reg : '0;
            out_len_reg    <= (res_status_reg == ST_HIT) ? found_len_reg : '0;
            out_lookup_reg <= lookup_next;
            out_hit_reg    <= hit_next;
            out_miss_reg   <= miss_next;
            out_error_reg  <= error_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.found_offset = out_off_reg;
    assign rsp.found_length = out_len_reg;
    assign rsp.lookup_total = out_lookup_reg;
    assign rsp.hit_total    = out_hit_reg;
    assign rsp.miss_total   = out_miss_reg;
    assign rsp.error_total  = out_error_reg;

    // The table never holds more entries than it has room for
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above table size");

    // A probe always has a non-empty search window
    a_probe_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (lo_reg < hi_reg))
        else $error("probe with empty search window");

    // The right walk only reads stored entries
    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR_RD) |-> (walk_reg < count_reg))
        else $error("right walk beyond stored entries");

endmodule

### rtl/skt_entry_mem.sv
// Entry store: one write port and one read port with registered read data.
// Depends on skt_pkg.
module skt_entry_mem import skt_pkg::*;
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [MAX_ENTRIES];

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one entry, data valid the next cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/skt_key_cmp.sv
// Shared 256-bit key comparator: unsigned, word NUM_WORDS-1 most significant.
// Depends on skt_pkg.
module skt_key_cmp import skt_pkg::*;
(
    input  key_t     stored_key,
    input  key_t     search_key,
    output cmp_res_t order
);

    // Walk from the least significant word up; the highest differing word wins
    always_comb
    begin
        order = '0;
        for (int w = 0; w < NUM_WORDS; w++)
        begin
            if (stored_key[w] != search_key[w])
            begin
                order.lt = stored_key[w] < search_key[w];
                order.gt = stored_key[w] > search_key[w];
            end
        end
    end

endmodule

### sim/tb_top.sv
// Testbench for the sorted key table lookup block: drives append, clear and lookup
// requests, predicts each response from its own copy of the table, and checks them.
// Depends on skt_pkg, skt_req_if, skt_rsp_if and sorted_key_table_lookup.
module tb_top;
    import skt_pkg::*;

    localparam logic [1:0]            REQ_RESERVED      = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] MAPPED_BYTES_ADDR = {CFG_IDX_MAPPED, 3'b000};
    localparam word_t                 WORD_MAX          = '1;
    localparam int                    RANDOM_ITEMS      = 900;
    localparam int                    DRAIN_CYCLES      = 40;
    localparam int                    BACKPRESSURE_HOLD = 300;

    typedef logic [NUM_WORDS*WORD_W-1:0] key_bits_t;

    typedef struct {
        logic [1:0]       kind;
        key_bits_t        key;
        logic [TID_W-1:0] tid;
        word_t            off;
        word_t            len;
    } table_req_t;

    typedef struct {
        logic [2:0]       status;
        word_t            found_offset;
        word_t            found_length;
        logic [CTR_W-1:0] lookup_total;
        logic [CTR_W-1:0] hit_total;
        logic [CTR_W-1:0] miss_total;
        logic [CTR_W-1:0] error_total;
    } lookup_result_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    skt_req_if req_if ();
    skt_rsp_if rsp_if ();

    sorted_key_table_lookup dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predicted table contents, counters and mapped size
    key_bits_t        tbl_key [MAX_ENTRIES];
    logic [TID_W-1:0] tbl_tid [MAX_ENTRIES];
    word_t            tbl_off [MAX_ENTRIES];
    word_t            tbl_len [MAX_ENTRIES];
    int               tbl_count    = 0;
    logic [CTR_W-1:0] lookup_count = '0;
    logic [CTR_W-1:0] hit_count    = '0;
    logic [CTR_W-1:0] miss_count   = '0;
    logic [CTR_W-1:0] error_count  = '0;
    word_t            mapped_limit = '0;

    lookup_result_t pending_results [$];
    int             mismatch_count    = 0;
    bit             req_gaps_on       = 1'b1;
    bit             rsp_stalls_on     = 1'b1;
    int             rsp_hold_request  = 0;

    // Clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Timeout
    initial begin
        #50_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic word_t rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic key_bits_t rand_key();
        return {rand_word(), rand_word(), rand_word(), rand_word()};
    endfunction

    // Mostly back-to-back, sometimes a short gap, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic table_req_t table_request(input logic [1:0] kind, input key_bits_t key,
                                                 input logic [TID_W-1:0] tid, input word_t off,
                                                 input word_t len);
        table_req_t it;
        it.kind = kind;
        it.key  = key;
        it.tid  = tid;
        it.off  = off;
        it.len  = len;
        return it;
    endfunction

    // Binary search with the walk across equal keys; returns whether found, index in at
    function automatic bit find_entry(input key_bits_t key, input logic [TID_W-1:0] tid,
                                      output int at);
        int lo;
        int hi;
        int mid;
        int j;
        lo = 0;
        hi = tbl_count;
        at = 0;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (tbl_key[mid] < key)
                lo = mid + 1;
            else if (tbl_key[mid] > key)
                hi = mid;
            else begin
                if (tbl_tid[mid] == tid) begin
                    at = mid;
                    return 1'b1;
                end
                // Walk left, then right, across equal keys
                for (j = mid; j > 0; j--) begin
                    if (tbl_key[j-1] != key)
                        break;
                    if (tbl_tid[j-1] == tid) begin
                        at = j - 1;
                        return 1'b1;
                    end
                end
                for (j = mid + 1; j < tbl_count; j++) begin
                    if (tbl_key[j] != key)
                        break;
                    if (tbl_tid[j] == tid) begin
                        at = j;
                        return 1'b1;
                    end
                end
                return 1'b0;
            end
        end
        return 1'b0;
    endfunction

    // Update the predicted table for one accepted request and queue its response
    function automatic void predict_table_step(input table_req_t it);
        lookup_result_t r;
        int             at;
        logic [WORD_W:0] span;
        r.status       = ST_ACK;
        r.found_offset = '0;
        r.found_length = '0;
        case (it.kind)
            REQ_CLEAR: begin
                tbl_count    = 0;
                lookup_count = '0;
                hit_count    = '0;
                miss_count   = '0;
                error_count  = '0;
            end
            REQ_APPEND: begin
                if (tbl_count >= MAX_ENTRIES)
                    r.status = ST_FULL;
                else begin
                    tbl_key[tbl_count] = it.key;
                    tbl_tid[tbl_count] = it.tid;
                    tbl_off[tbl_count] = it.off;
                    tbl_len[tbl_count] = it.len;
                    tbl_count++;
                end
            end
            REQ_LOOKUP: begin
                lookup_count++;
                if (find_entry(it.key, it.tid, at)) begin
                    span = {1'b0, tbl_off[at]} + {1'b0, tbl_len[at]};
                    if (span > {1'b0, mapped_limit}) begin
                        error_count++;
                        r.status = ST_ERR;
                    end else begin
                        hit_count++;
                        r.status       = ST_HIT;
                        r.found_offset = tbl_off[at];
                        r.found_length = tbl_len[at];
                    end
                end else begin
                    miss_count++;
                    r.status = ST_MISS;
                end
            end
            default: ;
        endcase
        r.lookup_total = lookup_count;
        r.hit_total    = hit_count;
        r.miss_total   = miss_count;
        r.error_total  = error_count;
        pending_results.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < 50)
            $display("%0t mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Offer one request, hold it until accepted, then predict its response
    task automatic send_table_request(input table_req_t it);
        int gap;
        gap = req_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.req_type    <= it.kind;
        req_if.key_word0   <= it.key[4*WORD_W-1:3*WORD_W];
        req_if.key_word1   <= it.key[3*WORD_W-1:2*WORD_W];
        req_if.key_word2   <= it.key[2*WORD_W-1:WORD_W];
        req_if.key_word3   <= it.key[WORD_W-1:0];
        req_if.table_tag   <= it.tid;
        req_if.blob_offset <= it.off;
        req_if.blob_length <= it.len;
        do @(posedge clk); while (!req_if.ready);
        predict_table_step(it);
    endtask

    // Stop offering and wait until every response has come back
    task automatic wait_for_drain();
        req_if.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Write mapped_bytes while idle, then read it back
    task automatic set_mapped_bytes(input word_t value);
        logic [CFG_DATA_W-1:0] readback;
        wait_for_drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAPPED_BYTES_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        mapped_limit = value;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (readback !== value)
            report_mismatch("mapped_bytes readback", readback, value);
    endtask

    // Response sink: random stalls, plus a long hold when a test asks for one
    initial begin : response_sink
        int stall_left;
        stall_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rsp_hold_request > 0) begin
                stall_left = rsp_hold_request;
                rsp_hold_request = 0;
            end else if (stall_left == 0 && rsp_stalls_on && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (stall_left > 0) begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end else
                rsp_if.ready <= 1'b1;
        end
    end

    // Compare each accepted response with the oldest prediction
    always @(posedge clk) begin : response_check
        lookup_result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0)
                report_mismatch("response with nothing pending", 64'(rsp_if.status), 64'd0);
            else begin
                want = pending_results.pop_front();
                if (rsp_if.status !== want.status)
                    report_mismatch("status", 64'(rsp_if.status), 64'(want.status));
                if (rsp_if.found_offset !== want.found_offset)
                    report_mismatch("found_offset", rsp_if.found_offset, want.found_offset);
                if (rsp_if.found_length !== want.found_length)
                    report_mismatch("found_length", rsp_if.found_length, want.found_length);
                if (rsp_if.lookup_total !== want.lookup_total)
                    report_mismatch("lookup_total", 64'(rsp_if.lookup_total),
                                    64'(want.lookup_total));
                if (rsp_if.hit_total !== want.hit_total)
                    report_mismatch("hit_total", 64'(rsp_if.hit_total), 64'(want.hit_total));
                if (rsp_if.miss_total !== want.miss_total)
                    report_mismatch("miss_total", 64'(rsp_if.miss_total), 64'(want.miss_total));
                if (rsp_if.error_total !== want.error_total)
                    report_mismatch("error_total", 64'(rsp_if.error_total),
                                    64'(want.error_total));
            end
        end
    end

    // Empty table, reserved request, key and blob extremes, bounds edges, clear
    task automatic test_extremes_and_bounds();
        key_bits_t k1;
        key_bits_t k2;
        key_bits_t k3;
        key_bits_t k4;
        k1 = {192'd0, WORD_MAX};
        k2 = {128'd0, WORD_MAX, 64'd0};
        k3 = {64'd0, WORD_MAX, 128'd0};
        k4 = {WORD_MAX, 192'd0};
        send_table_request(table_request(REQ_LOOKUP, '0, 8'h00, '0, '0));
        send_table_request(table_request(REQ_RESERVED, '1, 8'hFF, WORD_MAX, WORD_MAX));
        send_table_request(table_request(REQ_APPEND, '0, 8'h00, '0, '0));
        send_table_request(table_request(REQ_LOOKUP, '0, 8'h00, '0, '0));
        set_mapped_bytes(WORD_MAX);
        send_table_request(table_request(REQ_APPEND, k1, 8'h5A, 64'd60, 64'd40));
        send_table_request(table_request(REQ_APPEND, k2, 8'hA5, 64'd60, 64'd41));
        send_table_request(table_request(REQ_APPEND, k3, 8'hFF, WORD_MAX - 64'd5, 64'd5));
        send_table_request(table_request(REQ_APPEND, k4, 8'h01, WORD_MAX, 64'd1));
        send_table_request(table_request(REQ_APPEND, '1, 8'h80, 64'h8000_0000_0000_0000,
                                         64'h8000_0000_0000_0000));
        send_table_request(table_request(REQ_LOOKUP, k1, 8'h5A, '0, '0));
        send_table_request(table_request(REQ_LOOKUP, k2, 8'hA5, '0, '0));
        send_table_request(table_request(REQ_LOOKUP, k3, 8'hFF, '0, '0));
        send_table_request(table_request(REQ_LOOKUP, k4, 8'h01, '0, '0));
        send_table_request(table_request(REQ_LOOKUP, '1, 8'h80, '0, '0));
        send_table_request(table_request(REQ_LOOKUP, k2 + 1'b1, 8'hA5, '0, '0));
        send_table_request(table_request(REQ_LOOKUP, '1, 8'h7F, '0, '0));
        // Offset plus length right at and just past the mapped size
        set_mapped_bytes(64'd100);
        send_table_request(table_request(REQ_LOOKUP, k1, 8'h5A, '0, '0));
        send_table_request(table_request(REQ_LOOKUP, k2, 8'hA5, '0, '0));
        set_mapped_bytes('0);
        send_table_request(table_request(REQ_LOOKUP, '0, 8'h00, '0, '0));
        send_table_request(table_request(REQ_CLEAR, '1, 8'hFF, WORD_MAX, WORD_MAX));
        send_table_request(table_request(REQ_LOOKUP, '0, 8'h00, '0, '0));
    endtask

    // Runs of equal keys with different table ids
    task automatic test_equal_key_walk();
        int i;
        set_mapped_bytes(WORD_MAX);
        send_table_request(table_request(REQ_CLEAR, '0, 8'h00, '0, '0));
        send_table_request(table_request(REQ_APPEND, 256'd10, 8'd1, 64'd100, 64'd1));
        for (i = 1; i <= 5; i++)
            send_table_request(table_request(REQ_APPEND, 256'd20, 8'(i), 64'(200 + i), 64'd2));
        send_table_request(table_request(REQ_APPEND, 256'd30, 8'd9, 64'd300, 64'd3));
        send_table_request(table_request(REQ_LOOKUP, 256'd20, 8'd1, '0, '0));
        send_table_request(table_request(REQ_LOOKUP, 256'd20, 8'd5, '0, '0));
        send_table_request(table_request(REQ_LOOKUP, 256'd20, 8'd3, '0, '0));
        send_table_request(table_request(REQ_LOOKUP, 256'd20, 8'd7, '0, '0));
        send_table_request(table_request(REQ_LOOKUP, 256'd10, 8'd1, '0, '0));
        send_table_request(table_request(REQ_LOOKUP, 256'd30, 8'd9, '0, '0));
        send_table_request(table_request(REQ_LOOKUP, 256'd30, 8'd1, '0, '0));
    endtask

    // Appends out of key order; the search result follows its probe sequence
    task automatic test_out_of_order_append();
        int keys [5];
        int i;
        keys = '{50, 20, 80, 10, 60};
        send_table_request(table_request(REQ_CLEAR, '0, 8'h00, '0, '0));
        for (i = 0; i < 5; i++)
            send_table_request(table_request(REQ_APPEND, key_bits_t'(keys[i]), 8'd1,
                                             64'(keys[i]), 64'd4));
        for (i = 0; i < 5; i++)
            send_table_request(table_request(REQ_LOOKUP, key_bits_t'(keys[i]), 8'd1, '0, '0));
        send_table_request(table_request(REQ_LOOKUP, 256'd35, 8'd1, '0, '0));
    endtask

    // Hold the response side for a long stretch while requests keep coming
    task automatic test_backpressure();
        int i;
        wait_for_drain();
        req_gaps_on = 1'b0;
        rsp_hold_request = BACKPRESSURE_HOLD;
        send_table_request(table_request(REQ_CLEAR, '0, 8'h00, '0, '0));
        for (i = 0; i < 15; i++)
            send_table_request(table_request(REQ_APPEND, key_bits_t'(i * 3), 8'(i), 64'(i), 64'd8));
        for (i = 0; i < 15; i++)
            send_table_request(table_request(REQ_LOOKUP, key_bits_t'(i * 3), 8'(i), '0, '0));
        req_gaps_on = 1'b1;
        wait_for_drain();
    endtask

    function automatic word_t pick_mapped();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return WORD_MAX;
            2:       return rand_word();
            3:       return word_t'($urandom);
            default: return word_t'($urandom_range(0, 1 << 20));
        endcase
    endfunction

    function automatic word_t pick_blob_word();
        case ($urandom_range(0, 5))
            0:       return word_t'($urandom_range(0, 1 << 16));
            1:       return rand_word();
            2:       return '0;
            3:       return WORD_MAX;
            default: return word_t'($urandom);
        endcase
    endfunction

    // Next key in ascending order: often equal, often a step in one of the words
    function automatic key_bits_t next_key(input key_bits_t k);
        key_bits_t d;
        key_bits_t nk;
        case ($urandom_range(0, 9))
            0, 1, 2: d = '0;
            3, 4:    d = key_bits_t'($urandom_range(1, 3));
            default: d = key_bits_t'(rand_word()) << (WORD_W * $urandom_range(0, 3));
        endcase
        nk = k + d;
        if (nk < k)
            nk = k;
        return nk;
    endfunction

    // Phases of clear, sorted appends and lookups with random content and noise
    task automatic test_random_traffic();
        int         sent;
        int         n_app;
        int         n_look;
        int         i;
        int         r;
        int         at;
        key_bits_t  k;
        table_req_t it;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            req_gaps_on   = ($urandom_range(0, 3) != 0);
            rsp_stalls_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) == 0)
                set_mapped_bytes(pick_mapped());
            if ($urandom_range(0, 7) != 0) begin
                send_table_request(table_request(REQ_CLEAR, rand_key(), 8'($urandom),
                                                 rand_word(), rand_word()));
                sent++;
            end
            case ($urandom_range(0, 5))
                0:       k = '0;
                1:       k = '1 - key_bits_t'($urandom_range(0, 40));
                default: k = rand_key() >> (WORD_W * $urandom_range(0, 3));
            endcase
            n_app = $urandom_range(0, 24);
            for (i = 0; i < n_app; i++) begin
                if ($urandom_range(0, 15) == 0)
                    it = table_request(REQ_APPEND, rand_key(), 8'($urandom), pick_blob_word(),
                                       pick_blob_word());
                else begin
                    k = next_key(k);
                    it = table_request(REQ_APPEND, k, 8'($urandom_range(0, 7)), pick_blob_word(),
                                       pick_blob_word());
                end
                send_table_request(it);
                sent++;
            end
            n_look = $urandom_range(4, 30);
            for (i = 0; i < n_look; i++) begin
                r = $urandom_range(0, 19);
                at = (tbl_count > 0) ? $urandom_range(0, tbl_count - 1) : 0;
                if (r < 12 && tbl_count > 0)
                    it = table_request(REQ_LOOKUP, tbl_key[at],
                                       ($urandom_range(0, 3) != 0) ? tbl_tid[at] : 8'($urandom),
                                       rand_word(), rand_word());
                else if (r < 15 && tbl_count > 0)
                    it = table_request(REQ_LOOKUP,
                                       $urandom_range(0, 1) ? tbl_key[at] + 1'b1
                                                            : tbl_key[at] - 1'b1,
                                       tbl_tid[at], '0, '0);
                else if (r == 17)
                    it = table_request(REQ_RESERVED, rand_key(), 8'($urandom), rand_word(),
                                       rand_word());
                else if (r == 18)
                    it = table_request(REQ_APPEND, rand_key(), 8'($urandom), pick_blob_word(),
                                       pick_blob_word());
                else if (r == 19)
                    it = table_request(REQ_CLEAR, '0, 8'h00, '0, '0);
                else
                    it = table_request(REQ_LOOKUP, rand_key(), 8'($urandom), '0, '0);
                send_table_request(it);
                sent++;
            end
        end
        req_gaps_on   = 1'b1;
        rsp_stalls_on = 1'b1;
    endtask

    // Fill the table, append past the end, search the full table, then clear
    task automatic test_table_full();
        int i;
        set_mapped_bytes(WORD_MAX);
        req_gaps_on   = 1'b0;
        rsp_stalls_on = 1'b0;
        send_table_request(table_request(REQ_CLEAR, '0, 8'h00, '0, '0));
        // Groups of eight equal keys, table ids 0..7 within each group
        for (i = 0; i < MAX_ENTRIES; i++)
            send_table_request(table_request(REQ_APPEND,
                                             key_bits_t'(i >> 3) << (3 * WORD_W),
                                             8'(i % 8), 64'(i), 64'd1));
        send_table_request(table_request(REQ_APPEND, '1, 8'hFF, WORD_MAX, WORD_MAX));
        send_table_request(table_request(REQ_APPEND, '1, 8'h00, '0, '0));
        rsp_stalls_on = 1'b1;
        send_table_request(table_request(REQ_LOOKUP, '0, 8'd0, '0, '0));
        send_table_request(table_request(REQ_LOOKUP,
                                         key_bits_t'(MAX_ENTRIES / 8 - 1) << (3 * WORD_W),
                                         8'd7, '0, '0));
        send_table_request(table_request(REQ_LOOKUP, key_bits_t'(123) << (3 * WORD_W),
                                         8'd4, '0, '0));
        send_table_request(table_request(REQ_LOOKUP, key_bits_t'(300) << (3 * WORD_W),
                                         8'd200, '0, '0));
        send_table_request(table_request(REQ_LOOKUP, key_bits_t'(MAX_ENTRIES) << (3 * WORD_W),
                                         8'd0, '0, '0));
        send_table_request(table_request(REQ_CLEAR, '0, 8'h00, '0, '0));
        req_gaps_on = 1'b1;
    endtask

    // Reset, run each test in turn, drain and report
    initial begin
        rst_n              <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.req_type    <= REQ_CLEAR;
        req_if.key_word0   <= '0;
        req_if.key_word1   <= '0;
        req_if.key_word2   <= '0;
        req_if.key_word3   <= '0;
        req_if.table_tag   <= '0;
        req_if.blob_offset <= '0;
        req_if.blob_length <= '0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes_and_bounds();
        test_equal_key_walk();
        test_out_of_order_append();
        test_backpressure();
        test_random_traffic();
        test_table_full();

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
